FILE: sv/gls_pkg.sv
package gls_pkg;

  localparam int MAP_COLS_DEF = 32;
  localparam int MAP_ROWS_DEF = 32;

  localparam int COORD_W = 5;
  localparam int ERR_W   = 10;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef logic [COORD_W-1:0]      coord_t;
  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic signed [ERR_W:0]   err2_t;

endpackage

FILE: sv/gls_ram.sv
module gls_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/grid_line_of_sight.sv
// Channel   Direction  Transfer when        Signals
// command   in         start && !busy       action map_col map_row is_wall
//                                           from_col from_row to_col to_row
// result    out        done (one cycle)     visible
//
// A write gives no result; busy stays low.
// A query walks the tiles up to the first wall
// or the end point (at most 32 tiles); done is registered after the check of the last tile.
// The rate is set by the single read port of the wall map, one tile per cycle.
// After reset, a clearing pass over all MAP_COLS * MAP_ROWS map cells holds busy high.
// The receiver cannot stall: each result shows for exactly one cycle.
module grid_line_of_sight #(
  parameter int MAP_COLS = gls_pkg::MAP_COLS_DEF,
  parameter int MAP_ROWS = gls_pkg::MAP_ROWS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic            action,
  input  gls_pkg::coord_t map_col,
  input  gls_pkg::coord_t map_row,
  input  logic            is_wall,
  input  gls_pkg::coord_t from_col,
  input  gls_pkg::coord_t from_row,
  input  gls_pkg::coord_t to_col,
  input  gls_pkg::coord_t to_row,
  output logic            done,
  output logic            visible
);

  localparam int DEPTH = MAP_COLS * MAP_ROWS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_WALK} state_t;

  state_t           state;
  logic [AW-1:0]    clr_addr;
  gls_pkg::coord_t  cur_col, cur_row, dst_col, dst_row;
  gls_pkg::err_t    dc, dr, err;
  logic             sc_neg, sr_neg, tile_in;

  logic             accept, q_start, w_start;
  gls_pkg::coord_t  dc_in, dr_in;
  gls_pkg::err2_t   e2;
  logic             step_c, step_r, at_end, hit;
  gls_pkg::err_t    err_next;
  gls_pkg::coord_t  col_next, row_next, rd_col, rd_row;
  logic             rd_in, wr_in, we, wdata;
  logic [AW-1:0]    raddr, waddr;
  logic [0:0]       rdata;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign q_start = accept && (action == gls_pkg::ACT_QUERY);
  assign w_start = accept && (action == gls_pkg::ACT_WRITE);

  assign dc_in = (from_col < to_col) ? (to_col - from_col) : (from_col - to_col);
  assign dr_in = (from_row < to_row) ? (to_row - from_row) : (from_row - to_row);

  assign e2       = gls_pkg::err2_t'(err) <<< 1;
  assign step_c   = (e2 >= gls_pkg::err2_t'(dr));
  assign step_r   = (e2 <= gls_pkg::err2_t'(dc));
  assign err_next = err + (step_c ? dr : gls_pkg::err_t'(0))
                        + (step_r ? dc : gls_pkg::err_t'(0));
  assign col_next = step_c ? (sc_neg ? cur_col - gls_pkg::COORD_W'(1)
                                     : cur_col + gls_pkg::COORD_W'(1)) : cur_col;
  assign row_next = step_r ? (sr_neg ? cur_row - gls_pkg::COORD_W'(1)
                                     : cur_row + gls_pkg::COORD_W'(1)) : cur_row;
  assign at_end   = (cur_col == dst_col) && (cur_row == dst_row);
  assign hit      = tile_in && rdata[0];

  assign rd_col = (state == ST_WALK) ? col_next : from_col;
  assign rd_row = (state == ST_WALK) ? row_next : from_row;
  assign rd_in  = (32'(rd_col) < 32'(MAP_COLS)) && (32'(rd_row) < 32'(MAP_ROWS));
  assign raddr  = rd_in ? AW'(32'(rd_row) * 32'(MAP_COLS) + 32'(rd_col)) : '0;

  assign wr_in = (32'(map_col) < 32'(MAP_COLS)) && (32'(map_row) < 32'(MAP_ROWS));
  assign we    = (state == ST_CLEAR) || (w_start && wr_in);
  assign waddr = (state == ST_CLEAR) ? clr_addr
               : (wr_in ? AW'(32'(map_row) * 32'(MAP_COLS) + 32'(map_col)) : '0);
  assign wdata = (state == ST_CLEAR) ? 1'b0 : is_wall;

  gls_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_start) begin
            state   <= ST_WALK;
            cur_col <= from_col;
            cur_row <= from_row;
            dst_col <= to_col;
            dst_row <= to_row;
            dc      <= gls_pkg::err_t'(dc_in);
            dr      <= -gls_pkg::err_t'(dr_in);
            err     <= gls_pkg::err_t'(dc_in) - gls_pkg::err_t'(dr_in);
            sc_neg  <= !(from_col < to_col);
            sr_neg  <= !(from_row < to_row);
            tile_in <= rd_in;
          end
        end
        ST_WALK: begin
          if (hit) begin
            done    <= 1'b1;
            visible <= 1'b0;
            state   <= ST_IDLE;
          end else if (at_end) begin
            done    <= 1'b1;
            visible <= 1'b1;
            state   <= ST_IDLE;
          end else begin
            cur_col <= col_next;
            cur_row <= row_next;
            err     <= err_next;
            tile_in <= rd_in;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/gls_checker.sv
module gls_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic action,
  input logic done
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == gls_pkg::ACT_QUERY) |=> busy)
    else $error("query transfer not followed by busy");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == gls_pkg::ACT_WRITE) |=> (!done && !busy))
    else $error("write transfer gave a result or stalled");

endmodule

bind grid_line_of_sight gls_checker u_gls_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .action (action),
  .done   (done)
);
